// File: design/idq_pkg.sv
// Package for the id queue with remove-by-value.
// Holds default sizes, the operation codes, the controller states and the
// command/status bundles shared by the controller, datapath and top level.
package idq_pkg;

  // Default sizing.
  localparam int DEPTH_DEF    = 16;
  localparam int ID_WIDTH_DEF = 8;
  localparam int FUNC_W       = 3;

  // Operation codes carried in the input tuser field.
  typedef enum logic [FUNC_W-1:0] {
    OP_APPEND = 3'd0,
    OP_TAKE   = 3'd1,
    OP_PEEK   = 3'd2,
    OP_REMOVE = 3'd3,
    OP_EXISTS = 3'd4
  } op_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_APPEND,
    S_HEAD,
    S_HEAD_WB,
    S_SWEEP,
    S_DRAIN,
    S_RESP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // latch the accepted transaction
    logic append;     // write id at the tail, or flag overflow
    logic head_rd;    // read the head entry
    logic head_ld;    // capture head entry, pop it on a take
    logic sweep_rd;   // read the next entry of a sweep
    logic sweep_end;  // last compare of a sweep, commit the new count
    logic publish;    // load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic rd_last;
    logic out_free;
  } status_t;

endpackage

// File: design/idq_ctrl.sv
// Controller for the id queue: sequences each transaction through its
// operation steps. Depends on idq_pkg for the state, op, command and status types.
module idq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  idq_pkg::op_t     in_func,
  input  idq_pkg::status_t status,
  output idq_pkg::cmd_t    cmd
);

  idq_pkg::state_t state_r;
  idq_pkg::state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= idq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      idq_pkg::S_IDLE: begin
        if (in_tvalid) begin
          unique case (in_func)
            idq_pkg::OP_APPEND: state_nxt = idq_pkg::S_APPEND;
            idq_pkg::OP_TAKE,
            idq_pkg::OP_PEEK: begin
              state_nxt = status.empty ? idq_pkg::S_RESP : idq_pkg::S_HEAD;
            end
            idq_pkg::OP_REMOVE,
            idq_pkg::OP_EXISTS: begin
              state_nxt = status.empty ? idq_pkg::S_RESP : idq_pkg::S_SWEEP;
            end
            default: state_nxt = idq_pkg::S_RESP;
          endcase
        end
      end
      idq_pkg::S_APPEND:  state_nxt = idq_pkg::S_RESP;
      idq_pkg::S_HEAD:    state_nxt = idq_pkg::S_HEAD_WB;
      idq_pkg::S_HEAD_WB: state_nxt = idq_pkg::S_RESP;
      idq_pkg::S_SWEEP: begin
        if (status.rd_last) begin
          state_nxt = idq_pkg::S_DRAIN;
        end
      end
      idq_pkg::S_DRAIN:   state_nxt = idq_pkg::S_RESP;
      idq_pkg::S_RESP: begin
        if (status.out_free) begin
          state_nxt = idq_pkg::S_IDLE;
        end
      end
      default:            state_nxt = idq_pkg::S_IDLE;
    endcase
  end

  // Command decode.
  always_comb begin
    in_tready     = (state_r == idq_pkg::S_IDLE);
    cmd           = '0;
    cmd.load      = (state_r == idq_pkg::S_IDLE) && in_tvalid;
    cmd.append    = (state_r == idq_pkg::S_APPEND);
    cmd.head_rd   = (state_r == idq_pkg::S_HEAD);
    cmd.head_ld   = (state_r == idq_pkg::S_HEAD_WB);
    cmd.sweep_rd  = (state_r == idq_pkg::S_SWEEP);
    cmd.sweep_end = (state_r == idq_pkg::S_DRAIN);
    cmd.publish   = (state_r == idq_pkg::S_RESP) && status.out_free;
  end

endmodule

// File: design/idq_dp.sv
// Datapath for the id queue: circular entry memory, count and head pointer,
// compacting sweep and the result register. Depends on idq_pkg.
module idq_dp #(
  parameter int DEPTH    = idq_pkg::DEPTH_DEF,
  parameter int ID_WIDTH = idq_pkg::ID_WIDTH_DEF,
  localparam int AW      = $clog2(DEPTH),
  localparam int CNT_W   = $clog2(DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  idq_pkg::cmd_t       cmd,
  output idq_pkg::status_t    status,
  input  idq_pkg::op_t        in_func,
  input  logic [ID_WIDTH-1:0] in_id,
  input  logic                out_tready,
  output logic                out_valid,
  output logic [ID_WIDTH-1:0] out_head_id,
  output logic                out_found,
  output logic [CNT_W-1:0]    out_count,
  output logic                out_is_empty,
  output logic                out_overflow
);

  // Entry memory, addressed in circular order from the head pointer.
  logic [ID_WIDTH-1:0] mem [DEPTH];

  logic [CNT_W-1:0]    cnt_r;
  logic [AW-1:0]       head_r;
  logic                rd_vld_r;
  logic                out_valid_r;
  idq_pkg::op_t        op_r;
  logic [ID_WIDTH-1:0] id_r;
  logic                found_r;
  logic                ovf_r;
  logic [ID_WIDTH-1:0] head_id_r;
  logic [CNT_W-1:0]    rd_idx_r;
  logic [CNT_W-1:0]    kept_r;
  logic [ID_WIDTH-1:0] rd_data_r;
  logic [ID_WIDTH-1:0] out_head_id_r;
  logic                out_found_r;
  logic [CNT_W-1:0]    out_count_r;
  logic                out_is_empty_r;
  logic                out_overflow_r;

  logic                full;
  logic                empty;
  logic                sweep_keep;
  logic [CNT_W-1:0]    kept_nxt;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [ID_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]       mem_raddr;

  // Physical address of a logical position: head plus offset, wrapped once.
  function automatic logic [AW-1:0] wrap_addr(input logic [AW-1:0] base,
                                              input logic [CNT_W-1:0] ofs);
    logic [CNT_W:0] sum;
    sum = {{(CNT_W + 1 - AW){1'b0}}, base} + {1'b0, ofs};
    if (sum >= (CNT_W + 1)'(DEPTH)) begin
      sum = sum - (CNT_W + 1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  // Occupancy flags and the sweep compare stage.
  assign full       = (cnt_r == CNT_W'(DEPTH));
  assign empty      = (cnt_r == '0);
  assign sweep_keep = rd_vld_r && (op_r == idq_pkg::OP_REMOVE) && (rd_data_r != id_r);
  assign kept_nxt   = kept_r + CNT_W'(sweep_keep);

  // Memory port selection: tail append or compaction write, head or sweep read.
  assign mem_we    = (cmd.append && !full) || sweep_keep;
  assign mem_waddr = cmd.append ? wrap_addr(head_r, cnt_r) : wrap_addr(head_r, kept_r);
  assign mem_wdata = cmd.append ? id_r : rd_data_r;
  assign mem_raddr = cmd.head_rd ? head_r : wrap_addr(head_r, rd_idx_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  // Status toward the controller.
  always_comb begin
    status          = '0;
    status.empty    = empty;
    status.rd_last  = ((rd_idx_r + CNT_W'(1)) == cnt_r);
    status.out_free = !out_valid_r || out_tready;
  end

  // Control registers: count, head pointer, pipeline and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      head_r      <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.sweep_rd;
      if (cmd.append && !full) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (cmd.head_ld && (op_r == idq_pkg::OP_TAKE)) begin
        cnt_r  <= cnt_r - CNT_W'(1);
        head_r <= wrap_addr(head_r, CNT_W'(1));
      end else if (cmd.sweep_end && (op_r == idq_pkg::OP_REMOVE)) begin
        cnt_r <= kept_nxt;
      end
      if (cmd.publish) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Transaction payload, sweep indexes and the result register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= in_func;
      id_r      <= in_id;
      found_r   <= 1'b0;
      ovf_r     <= 1'b0;
      head_id_r <= '0;
      rd_idx_r  <= '0;
      kept_r    <= '0;
    end else begin
      if (cmd.append && full) begin
        ovf_r <= 1'b1;
      end
      if (cmd.head_ld) begin
        head_id_r <= rd_data_r;
      end
      if (cmd.sweep_rd) begin
        rd_idx_r <= rd_idx_r + CNT_W'(1);
      end
      if (rd_vld_r) begin
        if (rd_data_r == id_r) begin
          found_r <= 1'b1;
        end
        kept_r <= kept_nxt;
      end
    end
    if (cmd.publish) begin
      out_head_id_r  <= head_id_r;
      out_found_r    <= found_r && (op_r == idq_pkg::OP_EXISTS);
      out_count_r    <= cnt_r;
      out_is_empty_r <= empty;
      out_overflow_r <= ovf_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_head_id  = out_head_id_r;
  assign out_found    = out_found_r;
  assign out_count    = out_count_r;
  assign out_is_empty = out_is_empty_r;
  assign out_overflow = out_overflow_r;

endmodule

// File: design/id_queue_with_remove.sv
// Top level of the id queue with remove-by-value: ports, field packing and
// checks. Instantiates idq_ctrl and idq_dp; depends on idq_pkg.
//
// Usage:
//   Input transaction: in_tuser carries the operation (append, take head,
//   peek head, remove all matching, exists query), in_tdata the id.
//   Output transaction: one per input, in input order, carrying
//   the head id, found flag, count, empty flag and overflow flag.
// Sequence: append passes through an append step; take or peek read the head
//   and then capture it; remove or exists sweep every entry and then drain;
//   take, peek, remove or exists on an empty queue and unused operation codes
//   go straight to the result step, with which every operation ends.
// Throughput: one transaction at a time; the next is taken in the cycle after
//   the result is loaded. The remove and exists sweep reads one entry per
//   cycle through the single memory read port, compacting in place behind
//   the read.
// Reset: the queue is emptied and no result is pending; entry contents are
//   left as they were and are only read after being written.
// Stall: the result register holds while out_tready is low; a following
//   transaction is still accepted and processed, and waits only to publish.
module id_queue_with_remove #(
  parameter int DEPTH    = idq_pkg::DEPTH_DEF,
  parameter int ID_WIDTH = idq_pkg::ID_WIDTH_DEF,
  localparam int CNT_W      = $clog2(DEPTH + 1),
  localparam int IN_DATA_W  = ((ID_WIDTH + 7) / 8) * 8,
  localparam int OUT_BITS   = ID_WIDTH + CNT_W + 3,
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [IN_DATA_W-1:0]      in_tdata,   // var_id
  input  logic [idq_pkg::FUNC_W-1:0] in_tuser,  // func
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [OUT_DATA_W-1:0]     out_tdata   // head_id, found, count, is_empty, overflow
);

  idq_pkg::cmd_t       cmd;
  idq_pkg::status_t    status;
  idq_pkg::op_t        in_func;
  logic [ID_WIDTH-1:0] in_id;
  logic [ID_WIDTH-1:0] out_head_id;
  logic                out_found;
  logic [CNT_W-1:0]    out_count;
  logic                out_is_empty;
  logic                out_overflow;

  // Input field unpacking.
  assign in_func = idq_pkg::op_t'(in_tuser);
  assign in_id   = in_tdata[ID_WIDTH-1:0];

  idq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_func   (in_func),
    .status    (status),
    .cmd       (cmd)
  );

  idq_dp #(
    .DEPTH    (DEPTH),
    .ID_WIDTH (ID_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .in_func      (in_func),
    .in_id        (in_id),
    .out_tready   (out_tready),
    .out_valid    (out_tvalid),
    .out_head_id  (out_head_id),
    .out_found    (out_found),
    .out_count    (out_count),
    .out_is_empty (out_is_empty),
    .out_overflow (out_overflow)
  );

  // Output field packing, zero-filled to whole bytes.
  assign out_tdata = OUT_DATA_W'({out_overflow, out_is_empty, out_count,
                                  out_found, out_head_id});

`ifndef ASSERT_OFF
  // The reported count never exceeds the queue depth.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_count <= CNT_W'(DEPTH)))
    else $error("reported count exceeds depth");

  // A dropped append is only reported with a full queue.
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_overflow) |-> (out_count == CNT_W'(DEPTH)))
    else $error("overflow reported on a queue that is not full");

  // The empty flag agrees with the reported count.
  a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_is_empty == (out_count == '0)))
    else $error("empty flag disagrees with count");

  // No new transaction is taken while a sweep is reading the memory.
  a_sweep_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.sweep_rd || cmd.sweep_end) |-> !in_tready)
    else $error("input accepted during a sweep");
`endif

endmodule

// File: tb/idq_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the id queue: predicts one result per input transaction
// and compares it against the output channel. Depends on idq_pkg.
module idq_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  input  logic                       in_tready,
  input  logic [7:0]                 in_tdata,   // var_id
  input  logic [idq_pkg::FUNC_W-1:0] in_tuser,   // func
  input  logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic [15:0]                out_tdata,  // head_id, found, count, is_empty, overflow
  output int                         fails,
  output int                         pending
);
  import idq_pkg::*;

  localparam int QDEPTH = DEPTH_DEF;

  // Result fields, last field in the lowest bits.
  typedef struct packed {
    logic       overflow;
    logic       is_empty;
    logic [4:0] count;
    logic       found;
    logic [7:0] head_id;
  } status_word_t;

  // Shadow copy of the queue contents.
  logic [7:0]   shadow_ids [QDEPTH];
  int unsigned  shadow_count;
  status_word_t status_q [$];

  // Applies one operation to the shadow queue and returns the status word.
  function automatic status_word_t apply_op(input logic [FUNC_W-1:0] fn,
                                            input logic [7:0] id);
    status_word_t r;
    int unsigned  kept;
    r = '0;
    case (fn)
      OP_APPEND: begin
        if (shadow_count < QDEPTH) begin
          shadow_ids[shadow_count] = id;
          shadow_count++;
        end else begin
          r.overflow = 1'b1;
        end
      end
      OP_TAKE: begin
        if (shadow_count > 0) begin
          r.head_id = shadow_ids[0];
          for (int i = 1; i < shadow_count; i++) shadow_ids[i-1] = shadow_ids[i];
          shadow_count--;
        end
      end
      OP_PEEK: begin
        if (shadow_count > 0) r.head_id = shadow_ids[0];
      end
      OP_REMOVE: begin
        // Compact the survivors toward the head, keeping their order.
        kept = 0;
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_ids[i] != id) begin
            shadow_ids[kept] = shadow_ids[i];
            kept++;
          end
        end
        shadow_count = kept;
      end
      OP_EXISTS: begin
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_ids[i] == id) r.found = 1'b1;
        end
      end
      default: ;
    endcase
    r.count    = shadow_count[4:0];
    r.is_empty = (shadow_count == 0);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    fails++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got_v,
                             input logic [7:0] want_v);
    if (got_v !== want_v)
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got_v, want_v));
  endtask

  // Results are checked before new transactions are predicted, since a
  // result taken at an edge never belongs to the input taken at that edge.
  always @(posedge clk) begin
    status_word_t got;
    status_word_t want;
    if (!rst_n) begin
      status_q.delete();
      shadow_count = 0;
      fails = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = status_word_t'(out_tdata);
        if (status_q.size() == 0) begin
          report_mismatch($sformatf("result %h with no transaction outstanding",
                                    out_tdata));
        end else begin
          want = status_q.pop_front();
          check_field("head_id", got.head_id, want.head_id);
          check_field("found", got.found, want.found);
          check_field("count", got.count, want.count);
          check_field("is_empty", got.is_empty, want.is_empty);
          check_field("overflow", got.overflow, want.overflow);
        end
      end
      if (in_tvalid && in_tready) begin
        status_q.insert(status_q.size(), apply_op(in_tuser, in_tdata));
      end
    end
    pending = status_q.size();
  end

endmodule

// File: tb/id_queue_with_remove_test.sv
`timescale 1ns / 100ps
// Top of the id queue testbench: clock, reset, stimulus and verdict.
// Instantiates id_queue_with_remove and idq_checker; depends on idq_pkg.
module id_queue_with_remove_test;
  import idq_pkg::*;

  localparam int ID_W           = ID_WIDTH_DEF;
  localparam int OUT_W          = ((ID_W + $clog2(DEPTH_DEF + 1) + 3 + 7) / 8) * 8;
  localparam int FUNC_MAX       = (1 << FUNC_W) - 1;
  localparam int PHASES         = 12;
  localparam int PHASE_ITEMS    = 72;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int IDLE_LIMIT     = 2000;
  localparam int DRAIN_CYCLES   = 24;

  // Operation mix of one random phase.
  typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} op_mix_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [ID_W-1:0]   in_tdata;   // var_id
  logic [FUNC_W-1:0] in_tuser;   // func
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_W-1:0]  out_tdata;  // head_id, found, count, is_empty, overflow
  int                fails;
  int                pending;
  bit                tx_gaps_on;
  bit                rx_gaps_on;
  bit                hold_off_req;
  int                stall_left;
  int                idle_cycles;

  id_queue_with_remove uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  idq_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fails      (fails),
    .pending    (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Gap lengths: mostly none or short, now and then long.
  function automatic int pick_gap(input bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Ids come mostly from a small pool so that removes and queries hit.
  function automatic logic [ID_W-1:0] pick_id();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return ID_W'($urandom_range(0, 7));
    if (r < 78) return '1;
    return ID_W'($urandom_range(0, (1 << ID_W) - 1));
  endfunction

  function automatic logic [FUNC_W-1:0] pick_op(input op_mix_t mix);
    int r;
    int n_append;
    int n_take;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  begin n_append = 55; n_take = 10; end
      MIX_DRAIN: begin n_append = 20; n_take = 35; end
      default:   begin n_append = 35; n_take = 20; end
    endcase
    if (r < n_append) return OP_APPEND;
    r -= n_append;
    if (r < n_take) return OP_TAKE;
    r -= n_take;
    if (r < 10) return OP_PEEK;
    if (r < 20) return OP_REMOVE;
    if (r < 41) return OP_EXISTS;
    if (r < 44) return FUNC_W'($urandom_range(int'(OP_EXISTS) + 1, FUNC_MAX));
    return OP_EXISTS;
  endfunction

  // Offers one transaction; entered and left at a falling edge.
  task automatic send_item(input logic [FUNC_W-1:0] fn, input logic [ID_W-1:0] id);
    int gap;
    gap = pick_gap(tx_gaps_on);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= id;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Fill pattern: zero, all ones and a repeated id among ordinary ones.
  function automatic logic [ID_W-1:0] fill_id(input int i);
    if (i == 0) return '0;
    if (i == DEPTH_DEF - 1) return '1;
    if (i % 2 == 1) return ID_W'(8'h5A);
    return ID_W'(i);
  endfunction

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    out_tready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (!rst_n) begin
        out_tready <= 1'b0;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_tready <= 1'b0;
        stall_left = HOLD_OFF_CYCLES;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        stall_left = pick_gap(rx_gaps_on);
      end
    end
  end

  // Watchdog on cycles without any input or output handshake.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    op_mix_t mix;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = OP_APPEND;
    tx_gaps_on   = 1'b1;
    rx_gaps_on   = 1'b1;
    hold_off_req = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Operations on an empty queue, including unused codes.
    send_item(OP_TAKE, '0);
    send_item(OP_PEEK, '1);
    send_item(OP_REMOVE, '0);
    send_item(OP_EXISTS, '0);
    send_item(FUNC_W'(int'(OP_EXISTS) + 1), '1);
    send_item(FUNC_W'(FUNC_MAX), '0);

    // Fill to the limit, then overflow.
    for (int i = 0; i < DEPTH_DEF; i++) send_item(OP_APPEND, fill_id(i));
    send_item(OP_APPEND, ID_W'(8'h33));

    // Query, remove duplicates, remove an absent id, take the zero id at the head, then peek.
    send_item(OP_EXISTS, '1);
    send_item(OP_REMOVE, ID_W'(8'h5A));
    send_item(OP_REMOVE, ID_W'(8'h5A));
    send_item(OP_TAKE, '1);
    send_item(OP_PEEK, '0);

    // Random phases with varying mixes and idling.
    for (int p = 0; p < PHASES; p++) begin
      mix        = op_mix_t'($urandom_range(0, 2));
      tx_gaps_on = (p == 4) ? 1'b0 : 1'($urandom_range(0, 1));
      rx_gaps_on = 1'($urandom_range(0, 1));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // Long receiver hold-off while the sender keeps offering items.
        if (p == 4 && k == 10) hold_off_req = 1'b1;
        send_item(pick_op(mix), pick_id());
      end
    end
    in_tvalid <= 1'b0;

    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
design/idq_pkg.sv
design/idq_ctrl.sv
design/idq_dp.sv
design/id_queue_with_remove.sv
tb/idq_checker.sv
tb/id_queue_with_remove_test.sv
